/* sv/fnj_pkg.sv */
// Shared types and constants of the face normal and Jacobian pipeline.
package fnj_pkg;

    localparam int TAN_W     = 32;
    localparam int JAC_W     = 32;
    localparam int NORM_W    = 32;
    localparam int NORM_FRAC = 30;
    localparam int A_W       = 31;
    localparam int QUO_W     = 31;
    localparam int LEN_W     = 32;

    localparam logic [QUO_W-1:0]  NORM_ONE     = QUO_W'(1) << NORM_FRAC;
    localparam logic [NORM_W-1:0] NORM_ONE_OUT = NORM_W'(1) << NORM_FRAC;

    localparam logic [1:0] DIM_2D = 2'd2;
    localparam logic [1:0] DIM_3D = 2'd3;

    typedef struct packed {
        logic signed [TAN_W-1:0] t1x;
        logic signed [TAN_W-1:0] t1y;
        logic signed [TAN_W-1:0] t1z;
        logic signed [TAN_W-1:0] t2x;
        logic signed [TAN_W-1:0] t2y;
        logic signed [TAN_W-1:0] t2z;
        logic                    last;
        logic [1:0]              dim;
    } beat_t;

    typedef struct packed {
        logic [63:0]           sum;
        logic [2:0][A_W-1:0]   a;
        logic [2:0]            neg;
        logic [1:0]            dim;
        logic                  last;
    } sq1_side_t;

    typedef struct packed {
        logic [JAC_W-1:0]      jac;
        logic                  deg;
        logic [2:0][A_W-1:0]   a;
        logic [2:0]            neg;
        logic [1:0]            dim;
        logic                  last;
    } sq2_side_t;

    typedef struct packed {
        logic [JAC_W-1:0]      jac;
        logic                  deg;
        logic [2:0]            neg;
        logic [1:0]            dim;
        logic                  last;
    } div_side_t;

endpackage

/* sv/fnj_front.sv */
// Front pipeline: cross product, magnitudes, squared length and normalized components.
module fnj_front
    import fnj_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         ce,
    input  logic         in_valid,
    input  beat_t        beat,
    output logic         out_valid,
    output logic [127:0] sq_sum,
    output sq1_side_t    side
);

    typedef logic [3:0][63:0] norm_t;

    typedef struct packed {
        logic [2:0] neg;
        logic [1:0] dim;
        logic       last;
    } ctl_t;

    function automatic norm_t norm_step(input norm_t x, input int k);
        norm_t y;
        y = x;
        if ((x[0] >> (64 - k)) == 64'd0)
        begin
            for (int i = 0; i < 4; i++)
            begin
                y[i] = x[i] << k;
            end
        end
        return y;
    endfunction

    logic [9:0] vld_reg;

    // stage 1
    logic signed [63:0]      p_reg [6];
    logic signed [TAN_W-1:0] tx1_reg;
    logic signed [TAN_W-1:0] ty1_reg;
    logic [1:0]              dim1_reg;
    logic                    last1_reg;
    // stage 2
    logic signed [63:0]      v_reg [3];
    logic signed [63:0]      v_next [3];
    logic [1:0]              dim2_reg;
    logic                    last2_reg;
    // stage 3
    logic [63:0]             m3_reg [3];
    ctl_t                    c3_reg;
    // stage 4
    logic [63:0]             hh_reg [3];
    logic [63:0]             hl_reg [3];
    logic [63:0]             ll_reg [3];
    logic [63:0]             m4_reg [3];
    logic [63:0]             top4_reg;
    logic [63:0]             top_next;
    ctl_t                    c4_reg;
    // stage 5
    logic [127:0]            sq5_reg [3];
    norm_t                   n5_reg;
    ctl_t                    c5_reg;
    // stage 6
    logic [127:0]            s01_reg;
    logic [127:0]            sq2_reg;
    norm_t                   n6_reg;
    ctl_t                    c6_reg;
    // stage 7
    logic [127:0]            s7_reg;
    norm_t                   n7_reg;
    ctl_t                    c7_reg;
    // stage 8
    logic [127:0]            s8_reg;
    logic [2:0][A_W-1:0]     a8_reg;
    logic [61:0]             asq_reg [3];
    ctl_t                    c8_reg;
    // stage 9
    logic [127:0]            s9_reg;
    logic [2:0][A_W-1:0]     a9_reg;
    logic [62:0]             asum01_reg;
    logic [61:0]             asq2_reg;
    ctl_t                    c9_reg;
    // stage 10
    logic [127:0]            s10_reg;
    logic [2:0][A_W-1:0]     a10_reg;
    logic [63:0]             asum_reg;
    ctl_t                    c10_reg;

    logic signed [63:0] tx64;
    logic signed [63:0] ty64;
    logic [63:0]        top01;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[8:0], in_valid};
        end
    end

    assign tx64 = {{32{tx1_reg[TAN_W-1]}}, tx1_reg};
    assign ty64 = {{32{ty1_reg[TAN_W-1]}}, ty1_reg};

    always_comb
    begin
        case (dim1_reg)
            DIM_3D:
            begin
                v_next[0] = p_reg[0] - p_reg[1];
                v_next[1] = p_reg[2] - p_reg[3];
                v_next[2] = p_reg[4] - p_reg[5];
            end
            DIM_2D:
            begin
                v_next[0] = ty64 <<< FRAC_BITS;
                v_next[1] = (64'sd0 - tx64) <<< FRAC_BITS;
                v_next[2] = '0;
            end
            default:
            begin
                v_next[0] = '0;
                v_next[1] = '0;
                v_next[2] = '0;
            end
        endcase
    end

    assign top01    = (m3_reg[0] > m3_reg[1]) ? m3_reg[0] : m3_reg[1];
    assign top_next = (top01 > m3_reg[2]) ? top01 : m3_reg[2];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p_reg[0]  <= $signed(beat.t1y) * $signed(beat.t2z);
            p_reg[1]  <= $signed(beat.t1z) * $signed(beat.t2y);
            p_reg[2]  <= $signed(beat.t1z) * $signed(beat.t2x);
            p_reg[3]  <= $signed(beat.t1x) * $signed(beat.t2z);
            p_reg[4]  <= $signed(beat.t1x) * $signed(beat.t2y);
            p_reg[5]  <= $signed(beat.t1y) * $signed(beat.t2x);
            tx1_reg   <= beat.t1x;
            ty1_reg   <= beat.t1y;
            dim1_reg  <= beat.dim;
            last1_reg <= beat.last;

            v_reg     <= v_next;
            dim2_reg  <= dim1_reg;
            last2_reg <= last1_reg;

            for (int i = 0; i < 3; i++)
            begin
                m3_reg[i]     <= v_reg[i][63] ? 64'(-v_reg[i]) : 64'(v_reg[i]);
                c3_reg.neg[i] <= v_reg[i][63];
            end
            c3_reg.dim  <= dim2_reg;
            c3_reg.last <= last2_reg;

            for (int i = 0; i < 3; i++)
            begin
                hh_reg[i] <= m3_reg[i][63:32] * m3_reg[i][63:32];
                hl_reg[i] <= m3_reg[i][63:32] * m3_reg[i][31:0];
                ll_reg[i] <= m3_reg[i][31:0] * m3_reg[i][31:0];
            end
            m4_reg   <= m3_reg;
            top4_reg <= top_next;
            c4_reg   <= c3_reg;

            for (int i = 0; i < 3; i++)
            begin
                sq5_reg[i] <= {hh_reg[i], 64'd0} + {31'd0, hl_reg[i], 33'd0}
                              + {64'd0, ll_reg[i]};
            end
            n5_reg <= norm_step(norm_step({m4_reg[2], m4_reg[1], m4_reg[0], top4_reg}, 32), 16);
            c5_reg <= c4_reg;

            s01_reg <= sq5_reg[0] + sq5_reg[1];
            sq2_reg <= sq5_reg[2];
            n6_reg  <= norm_step(norm_step(n5_reg, 8), 4);
            c6_reg  <= c5_reg;

            s7_reg <= s01_reg + sq2_reg;
            n7_reg <= norm_step(norm_step(n6_reg, 2), 1);
            c7_reg <= c6_reg;

            s8_reg <= s7_reg;
            for (int i = 0; i < 3; i++)
            begin
                a8_reg[i]  <= n7_reg[i+1][63:33];
                asq_reg[i] <= n7_reg[i+1][63:33] * n7_reg[i+1][63:33];
            end
            c8_reg <= c7_reg;

            s9_reg     <= s8_reg;
            a9_reg     <= a8_reg;
            asum01_reg <= {1'b0, asq_reg[0]} + {1'b0, asq_reg[1]};
            asq2_reg   <= asq_reg[2];
            c9_reg     <= c8_reg;

            s10_reg  <= s9_reg;
            a10_reg  <= a9_reg;
            asum_reg <= {1'b0, asum01_reg} + {2'b00, asq2_reg};
            c10_reg  <= c9_reg;
        end
    end

    assign out_valid = vld_reg[9];
    assign sq_sum    = s10_reg;
    assign side      = '{sum: asum_reg, a: a10_reg, neg: c10_reg.neg,
                         dim: c10_reg.dim, last: c10_reg.last};

endmodule

/* sv/fnj_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
module fnj_isqrt
#(
    parameter int ROOT_W = 32,
    parameter int SIDE_W = 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  ce,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   in_rad,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     out_root,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic              vld_reg  [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_step
        logic              vld_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SIDE_W-1:0] side_in;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic              take;

        if (k == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign rad_in  = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign rem_sh = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (ce)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rad_reg[k]  <= rad_in << 2;
                rem_reg[k]  <= take ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
                root_reg[k] <= {root_in[ROOT_W-2:0], take};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

/* sv/fnj_divide.sv */
// Three-lane pipelined restoring divider for the rounded normal components.
module fnj_divide
    import fnj_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    ce,
    input  logic                    in_valid,
    input  logic [2:0][A_W-1:0]     a,
    input  logic [LEN_W-1:0]        len,
    input  logic [SIDE_W-1:0]       in_side,
    output logic                    out_valid,
    output logic [2:0][QUO_W-1:0]   quo,
    output logic [SIDE_W-1:0]       out_side
);

    localparam int DIV_W = A_W + NORM_FRAC + 1;
    localparam int DVS_W = DIV_W + 1;

    logic                  vld_reg  [QUO_W+1];
    logic [2:0][DIV_W-1:0] rem_reg  [QUO_W+1];
    logic [2:0][QUO_W-1:0] quo_reg  [QUO_W+1];
    logic [LEN_W-1:0]      dvs_reg  [QUO_W+1];
    logic [SIDE_W-1:0]     side_reg [QUO_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (ce)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= DIV_W'({a[i], {NORM_FRAC{1'b0}}}) + DIV_W'(len >> 1);
            end
            quo_reg[0]  <= '0;
            dvs_reg[0]  <= len;
            side_reg[0] <= in_side;
        end
    end

    for (genvar j = 1; j <= QUO_W; j++)
    begin : g_step
        localparam int K = QUO_W - j;
        logic [2:0][DIV_W-1:0] rem_next;
        logic [2:0][QUO_W-1:0] quo_next;
        logic [DVS_W-1:0]      dvs_sh;

        assign dvs_sh = DVS_W'(dvs_reg[j-1]) << K;

        always_comb
        begin
            rem_next = rem_reg[j-1];
            quo_next = quo_reg[j-1];
            for (int i = 0; i < 3; i++)
            begin
                if ({1'b0, rem_reg[j-1][i]} >= dvs_sh)
                begin
                    rem_next[i]    = DIV_W'({1'b0, rem_reg[j-1][i]} - dvs_sh);
                    quo_next[i][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (ce)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[j]  <= rem_next;
                quo_reg[j]  <= quo_next;
                dvs_reg[j]  <= dvs_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign out_valid = vld_reg[QUO_W];
    assign quo       = quo_reg[QUO_W];
    assign out_side  = side_reg[QUO_W];

endmodule

/* sv/face_unit_normal_and_jacobian_unit.sv */
// Top level: face point tangents in, surface Jacobian and unit normal out.
// Accepts one point per clock while pt_stall is low and returns one result per point, in
// order. The pipeline is made of the two root extractions (64 stages for the squared
// length, 32 for the normalized length, one root bit each) and the 32-stage normal
// divider; the front end adds 10 stages and the rounding and output registers 2. A
// one-beat skid register at the input takes one more point while a finished result
// waits, then raises pt_stall; a stalled output freezes the whole pipeline.
module face_unit_normal_and_jacobian_unit
    import fnj_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     dimension_we,
    input  logic [1:0]               dimension,
    input  logic                     pt_valid,
    output logic                     pt_stall,
    input  logic signed [TAN_W-1:0]  tan1_x,
    input  logic signed [TAN_W-1:0]  tan1_y,
    input  logic signed [TAN_W-1:0]  tan1_z,
    input  logic signed [TAN_W-1:0]  tan2_x,
    input  logic signed [TAN_W-1:0]  tan2_y,
    input  logic signed [TAN_W-1:0]  tan2_z,
    input  logic                     last_point,
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic [JAC_W-1:0]         jacobian,
    output logic signed [NORM_W-1:0] normal_x,
    output logic signed [NORM_W-1:0] normal_y,
    output logic signed [NORM_W-1:0] normal_z,
    output logic                     degenerate,
    output logic                     point_done
);

    localparam logic [JAC_W-1:0] JAC_ONE = JAC_W'(64'd1 << FRAC_BITS);

    logic [1:0] dimension_reg;
    logic       skid_full_reg;
    beat_t      skid_reg;
    beat_t      port_beat;
    beat_t      feed;
    logic       feed_valid;
    logic       accept;
    logic       ce;

    logic         fr_valid;
    logic [127:0] fr_sum;
    sq1_side_t    fr_side;

    logic        s1_valid;
    logic [63:0] s1_root;
    logic [$bits(sq1_side_t)-1:0] s1_side_raw;
    sq1_side_t   s1_side;

    logic [JAC_W:0]   jac_sum;
    logic [JAC_W-1:0] jac_sat;
    logic             j_valid_reg;
    logic [63:0]      j_sum_reg;
    sq2_side_t        j_side_reg;

    logic             s2_valid;
    logic [LEN_W-1:0] s2_root;
    logic [$bits(sq2_side_t)-1:0] s2_side_raw;
    sq2_side_t        s2_side;

    logic                  dv_valid;
    logic [2:0][QUO_W-1:0] dv_quo;
    logic [$bits(div_side_t)-1:0] dv_side_raw;
    div_side_t             dv_side;

    logic                    res_valid_reg;
    logic [JAC_W-1:0]        jacobian_reg;
    logic [JAC_W-1:0]        jacobian_next;
    logic [2:0][NORM_W-1:0]  normal_reg;
    logic [2:0][NORM_W-1:0]  normal_next;
    logic                    degenerate_reg;
    logic                    degenerate_next;
    logic                    point_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimension_reg <= DIM_3D;
        end
        else if (dimension_we)
        begin
            dimension_reg <= dimension;
        end
    end

    // input skid: hold one beat while the pipeline is frozen
    assign ce       = !res_valid_reg || !res_stall;
    assign pt_stall = skid_full_reg;
    assign accept   = pt_valid && !skid_full_reg;

    assign port_beat = '{t1x: tan1_x, t1y: tan1_y, t1z: tan1_z, t2x: tan2_x, t2y: tan2_y,
                         t2z: tan2_z, last: last_point, dim: dimension_reg};
    assign feed       = skid_full_reg ? skid_reg : port_beat;
    assign feed_valid = skid_full_reg || accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else if (ce)
        begin
            skid_full_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ce && accept)
        begin
            skid_reg <= port_beat;
        end
    end

    fnj_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (feed_valid),
        .beat      (feed),
        .out_valid (fr_valid),
        .sq_sum    (fr_sum),
        .side      (fr_side)
    );

    fnj_isqrt #(
        .ROOT_W (64),
        .SIDE_W ($bits(sq1_side_t))
    ) u_len_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (fr_valid),
        .in_rad    (fr_sum),
        .in_side   (fr_side),
        .out_valid (s1_valid),
        .out_root  (s1_root),
        .out_side  (s1_side_raw)
    );

    assign s1_side = sq1_side_t'(s1_side_raw);

    // round the length to nearest and saturate
    assign jac_sum = (JAC_W+1)'(s1_root >> FRAC_BITS) + (JAC_W+1)'(s1_root[FRAC_BITS-1]);
    assign jac_sat = ((s1_root >> FRAC_BITS) > 64'(32'hFFFF_FFFF) || jac_sum[JAC_W])
                     ? '1 : jac_sum[JAC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            j_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            j_sum_reg  <= s1_side.sum;
            j_side_reg <= '{jac: jac_sat, deg: (jac_sat == '0), a: s1_side.a,
                            neg: s1_side.neg, dim: s1_side.dim, last: s1_side.last};
        end
    end

    fnj_isqrt #(
        .ROOT_W (LEN_W),
        .SIDE_W ($bits(sq2_side_t))
    ) u_norm_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (j_valid_reg),
        .in_rad    (j_sum_reg),
        .in_side   (j_side_reg),
        .out_valid (s2_valid),
        .out_root  (s2_root),
        .out_side  (s2_side_raw)
    );

    assign s2_side = sq2_side_t'(s2_side_raw);

    fnj_divide #(
        .SIDE_W ($bits(div_side_t))
    ) u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s2_valid),
        .a         (s2_side.a),
        .len       (s2_root),
        .in_side   (div_side_t'{jac: s2_side.jac, deg: s2_side.deg, neg: s2_side.neg,
                                dim: s2_side.dim, last: s2_side.last}),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .out_side  (dv_side_raw)
    );

    assign dv_side = div_side_t'(dv_side_raw);

    always_comb
    begin
        logic [QUO_W-1:0] mag;
        jacobian_next   = dv_side.jac;
        degenerate_next = dv_side.deg;
        for (int i = 0; i < 3; i++)
        begin
            mag = (dv_quo[i] > NORM_ONE) ? NORM_ONE : dv_quo[i];
            normal_next[i] = dv_side.neg[i] ? NORM_W'(0) - {1'b0, mag} : {1'b0, mag};
            if (dv_side.deg)
            begin
                normal_next[i] = '0;
            end
        end
        if (dv_side.dim != DIM_2D && dv_side.dim != DIM_3D)
        begin
            jacobian_next   = JAC_ONE;
            degenerate_next = 1'b0;
            normal_next[0]  = NORM_ONE_OUT;
            normal_next[1]  = '0;
            normal_next[2]  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            res_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            jacobian_reg   <= jacobian_next;
            normal_reg     <= normal_next;
            degenerate_reg <= degenerate_next;
            point_done_reg <= dv_side.last;
        end
    end

    assign res_valid  = res_valid_reg;
    assign jacobian   = jacobian_reg;
    assign normal_x   = normal_reg[0];
    assign normal_y   = normal_reg[1];
    assign normal_z   = normal_reg[2];
    assign degenerate = degenerate_reg;
    assign point_done = point_done_reg;

endmodule

/* tb/fnj_checker.sv */
// Checker for the face normal and Jacobian unit: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module fnj_checker
    import fnj_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     dimension_we,
    input  logic [1:0]               dimension,
    input  logic                     pt_valid,
    input  logic                     pt_stall,
    input  logic signed [TAN_W-1:0]  tan1_x,
    input  logic signed [TAN_W-1:0]  tan1_y,
    input  logic signed [TAN_W-1:0]  tan1_z,
    input  logic signed [TAN_W-1:0]  tan2_x,
    input  logic signed [TAN_W-1:0]  tan2_y,
    input  logic signed [TAN_W-1:0]  tan2_z,
    input  logic                     last_point,
    input  logic                     res_valid,
    input  logic                     res_stall,
    input  logic [JAC_W-1:0]         jacobian,
    input  logic signed [NORM_W-1:0] normal_x,
    input  logic signed [NORM_W-1:0] normal_y,
    input  logic signed [NORM_W-1:0] normal_z,
    input  logic                     degenerate,
    input  logic                     point_done,
    output int                       fail_count,
    output int                       pending,
    output int                       degen_seen
);

    localparam int FRAC = 16;

    typedef struct packed {
        logic [JAC_W-1:0]  jac;
        logic [NORM_W-1:0] nx;
        logic [NORM_W-1:0] ny;
        logic [NORM_W-1:0] nz;
        logic              deg;
        logic              done;
    } face_res_t;

    face_res_t  expected_q[$];
    logic [1:0] dim_cfg;

    function automatic face_res_t predict_face(
        input logic [1:0] dim,
        input logic signed [31:0] t1x, t1y, t1z, t2x, t2y, t2z,
        input logic last
    );
        face_res_t         res;
        logic signed [65:0] ax, ay, az, bx, by, bz;
        logic signed [65:0] v [3];
        logic [127:0]      m [3];
        logic [127:0]      s, tt;
        logic [63:0]       r, t, top, jac, sq, len, n, l;
        logic [63:0]       a [3];
        int                bl;
        res = '0;
        res.done = last;
        if (dim < DIM_2D)
        begin
            res.jac = JAC_W'(1) << FRAC;
            res.nx  = NORM_ONE_OUT;
            return res;
        end
        ax = t1x; ay = t1y; az = t1z; bx = t2x; by = t2y; bz = t2z;
        if (dim == DIM_2D)
        begin
            v[0] = ay <<< FRAC;
            v[1] = -(ax <<< FRAC);
            v[2] = '0;
        end
        else
        begin
            v[0] = ay * bz - az * by;
            v[1] = az * bx - ax * bz;
            v[2] = ax * by - ay * bx;
        end
        s = '0;
        top = '0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (v[i] < 0) ? 128'(-v[i]) : 128'(v[i]);
            s = s + m[i] * m[i];
            if (m[i][63:0] > top)
                top = m[i][63:0];
        end
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            tt = 128'(t) * 128'(t);
            if (tt <= s)
                r = t;
        end
        jac = (r >> FRAC) + 64'(r[FRAC-1]);
        if (jac > 64'hFFFF_FFFF)
            jac = 64'hFFFF_FFFF;
        res.jac = jac[31:0];
        if (jac == 0)
        begin
            res.deg = 1'b1;
            return res;
        end
        bl = 0;
        while (bl < 64 && (top >> bl) != 0)
            bl++;
        sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = (bl > 31) ? m[i][63:0] >> (bl - 31) : m[i][63:0] << (31 - bl);
            sq = sq + a[i] * a[i];
        end
        len = '0;
        for (int b = 31; b >= 0; b--)
        begin
            l = len | (64'd1 << b);
            if (l * l <= sq)
                len = l;
        end
        for (int i = 0; i < 3; i++)
        begin
            n = ((a[i] << 30) + (len >> 1)) / len;
            if (n > (64'd1 << 30))
                n = 64'd1 << 30;
            if (v[i] < 0)
                n = -n;
            case (i)
                0: res.nx = n[31:0];
                1: res.ny = n[31:0];
                default: res.nz = n[31:0];
            endcase
        end
        return res;
    endfunction

    function automatic int field_bad(input string name, input logic [31:0] exp_v,
                                     input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        face_res_t want;
        int        bad;
        if (!rst_n)
        begin
            dim_cfg    = DIM_3D;
            fail_count = 0;
            degen_seen = 0;
            expected_q.delete();
        end
        else
        begin
            if (dimension_we)
                dim_cfg = dimension;
            if (pt_valid && !pt_stall)
                expected_q.push_back(predict_face(dim_cfg, tan1_x, tan1_y, tan1_z,
                                                  tan2_x, tan2_y, tan2_z, last_point));
            if (res_valid && !res_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result beat with none expected, jacobian %h",
                             $time, jacobian);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    bad = field_bad("jacobian", want.jac, jacobian)
                        + field_bad("normal_x", want.nx, normal_x)
                        + field_bad("normal_y", want.ny, normal_y)
                        + field_bad("normal_z", want.nz, normal_z)
                        + field_bad("degenerate", 32'(want.deg), 32'(degenerate))
                        + field_bad("point_done", 32'(want.done), 32'(point_done));
                    if (bad != 0)
                        fail_count++;
                    if (want.deg)
                        degen_seen++;
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

/* tb/tb_face_unit_normal_and_jacobian_unit.sv */
// Testbench top: drives tangents and dimension settings, holds the result side, reports.
`timescale 1ns / 100ps
module tb_face_unit_normal_and_jacobian_unit
    import fnj_pkg::*;
();

    localparam int HOLD_AT    = 60;
    localparam int HOLD_LEN   = 400;
    localparam int CALM_AT    = 780;
    localparam int DRAIN_WAIT = 160;
    localparam int CYC_LIMIT  = 400000;
    localparam logic signed [31:0] MAX_S = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN_S = 32'sh8000_0000;
    localparam logic signed [31:0] ONE   = 32'sh0001_0000;

    logic                     clk;
    logic                     rst_n;
    logic                     dimension_we;
    logic [1:0]               dimension;
    logic                     pt_valid;
    logic                     pt_stall;
    logic signed [TAN_W-1:0]  tan1_x, tan1_y, tan1_z, tan2_x, tan2_y, tan2_z;
    logic                     last_point;
    logic                     res_valid;
    logic                     res_stall;
    logic [JAC_W-1:0]         jacobian;
    logic signed [NORM_W-1:0] normal_x, normal_y, normal_z;
    logic                     degenerate;
    logic                     point_done;
    int                       fail_count;
    int                       pending;
    int                       degen_seen;
    int                       beats_sent;
    int                       cyc;
    bit                       held;

    face_unit_normal_and_jacobian_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .dimension_we(dimension_we), .dimension(dimension),
        .pt_valid(pt_valid), .pt_stall(pt_stall),
        .tan1_x(tan1_x), .tan1_y(tan1_y), .tan1_z(tan1_z),
        .tan2_x(tan2_x), .tan2_y(tan2_y), .tan2_z(tan2_z),
        .last_point(last_point),
        .res_valid(res_valid), .res_stall(res_stall),
        .jacobian(jacobian), .normal_x(normal_x), .normal_y(normal_y),
        .normal_z(normal_z), .degenerate(degenerate), .point_done(point_done)
    );

    fnj_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .dimension_we(dimension_we), .dimension(dimension),
        .pt_valid(pt_valid), .pt_stall(pt_stall),
        .tan1_x(tan1_x), .tan1_y(tan1_y), .tan1_z(tan1_z),
        .tan2_x(tan2_x), .tan2_y(tan2_y), .tan2_z(tan2_z),
        .last_point(last_point),
        .res_valid(res_valid), .res_stall(res_stall),
        .jacobian(jacobian), .normal_x(normal_x), .normal_y(normal_y),
        .normal_z(normal_z), .degenerate(degenerate), .point_done(point_done),
        .fail_count(fail_count), .pending(pending), .degen_seen(degen_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        res_stall = 1'b0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && beats_sent >= HOLD_AT)
            begin
                held = 1'b1;
                res_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
                res_stall <= 1'b0;
            end
            else if (beats_sent < CALM_AT && $urandom_range(0, 9) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cyc, pending);
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_comp();
        case ($urandom_range(0, 6))
            0: return 32'sh0;
            1: return ($urandom_range(0, 1) != 0) ? MAX_S : MIN_S;
            2: return 32'($signed($urandom_range(0, 6)) - 3);
            3: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
            4: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_point(input logic signed [31:0] ax, ay, az, bx, by, bz,
                              input logic last);
        pt_valid   <= 1'b1;
        tan1_x     <= ax;
        tan1_y     <= ay;
        tan1_z     <= az;
        tan2_x     <= bx;
        tan2_y     <= by;
        tan2_z     <= bz;
        last_point <= last;
        do
            @(posedge clk);
        while (pt_stall);
        beats_sent++;
        if (beats_sent < CALM_AT && $urandom_range(0, 7) == 0)
        begin
            pt_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic set_dimension(input logic [1:0] dim);
        pt_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        dimension_we <= 1'b1;
        dimension    <= dim;
        @(posedge clk);
        dimension_we <= 1'b0;
    endtask

    task automatic send_random(input int count);
        logic signed [31:0] ax, ay, az, bx, by, bz;
        int                 k;
        for (int i = 0; i < count; i++)
        begin
            ax = pick_comp(); ay = pick_comp(); az = pick_comp();
            bx = pick_comp(); by = pick_comp(); bz = pick_comp();
            if ($urandom_range(0, 9) == 0)
            begin
                k = $urandom_range(0, 3) - 2;
                bx = ax * k; by = ay * k; bz = az * k;
            end
            send_point(ax, ay, az, bx, by, bz, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        logic [1:0] dim_plan [8];
        int         seg_len [8];
        cyc          = 0;
        beats_sent   = 0;
        rst_n        = 1'b0;
        dimension_we = 1'b0;
        dimension    = DIM_3D;
        pt_valid     = 1'b0;
        tan1_x = '0; tan1_y = '0; tan1_z = '0;
        tan2_x = '0; tan2_y = '0; tan2_z = '0;
        last_point = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_dimension(DIM_3D);
        send_point(0, 0, 0, 0, 0, 0, 1'b0);
        send_point(ONE, 0, 0, 0, ONE, 0, 1'b1);
        send_point(0, ONE, 0, 0, 0, ONE, 1'b0);
        send_point(1, 0, 0, 0, 1, 0, 1'b0);
        send_point(ONE, ONE, ONE, -ONE, -ONE, -ONE, 1'b0);
        send_point(MAX_S, 0, 0, 0, MAX_S, 0, 1'b1);
        send_point(MIN_S, MIN_S, MIN_S, MAX_S, MIN_S, MAX_S, 1'b0);
        send_point(MIN_S, MAX_S, MIN_S, MAX_S, MIN_S, MAX_S, 1'b1);
        send_point(-1, -1, -1, 32'sh7FFF_0000, 3, -5, 1'b0);
        send_point(ONE, 2 * ONE, 0, -2 * ONE, ONE, 0, 1'b0);
        set_dimension(DIM_2D);
        send_point(0, 0, ONE, ONE, ONE, ONE, 1'b0);
        send_point(ONE, 0, 0, 0, 0, 0, 1'b1);
        send_point(-ONE, ONE, 0, 0, 0, 0, 1'b0);
        send_point(MIN_S, MIN_S, 0, 0, 0, 0, 1'b0);
        send_point(MAX_S, 0, 0, 0, 0, 0, 1'b1);
        send_point(1, 0, 0, 0, 0, 0, 1'b0);
        set_dimension(2'd1);
        send_point(MAX_S, MIN_S, ONE, 0, 0, 0, 1'b1);
        send_point(0, 0, 0, 0, 0, 0, 1'b0);
        set_dimension(2'd0);
        send_point(ONE, ONE, ONE, ONE, ONE, ONE, 1'b1);

        dim_plan = '{DIM_3D, DIM_2D, DIM_3D, 2'd1, DIM_2D, DIM_3D, 2'd0, DIM_3D};
        seg_len  = '{300, 100, 100, 40, 100, 100, 40, 50};
        foreach (dim_plan[p])
        begin
            set_dimension(dim_plan[p]);
            send_random(seg_len[p]);
        end

        pt_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("covered %0d points over dimensions 0 to 3, %0d degenerate results", beats_sent,
                 degen_seen);
        $display("included a %0d-cycle result hold with input backpressure", HOLD_LEN);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
sv/fnj_pkg.sv
sv/fnj_front.sv
sv/fnj_isqrt.sv
sv/fnj_divide.sv
sv/face_unit_normal_and_jacobian_unit.sv
tb/fnj_checker.sv
tb/tb_face_unit_normal_and_jacobian_unit.sv
